[hw/rtl/u2u_pkg.sv]
// ----------------------------------------------------------------------------
// u2u_pkg: shared types and constants for the UTF-8 to UTF-16 decoder
// Result beat layout, result bundle, configuration group and the code point
// limits used by the sequence checks.
// ----------------------------------------------------------------------------
package u2u_pkg;

   localparam int CODE_W      = 21;
   localparam int CERT_W      = 2;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_MODE    = 1'b1;

   // stream classes reported on the end beat
   localparam logic [CERT_W-1:0] CERT_ASCII   = 2'd0;
   localparam logic [CERT_W-1:0] CERT_UTF8    = 2'd1;
   localparam logic [CERT_W-1:0] CERT_INVALID = 2'd2;

   // code point limits
   localparam logic [CODE_W-1:0] CP_MAX      = 21'h10FFFF;
   localparam logic [CODE_W-1:0] CP_SUR_LO   = 21'h00D800;
   localparam logic [CODE_W-1:0] CP_SUR_HI   = 21'h00DFFF;
   localparam logic [CODE_W-1:0] CP_BMP_MAX  = 21'h00FFFF;
   localparam logic [CODE_W-1:0] CP_SUPP     = 21'h010000;
   localparam logic [CODE_W-1:0] CP_MIN2     = 21'h000080;
   localparam logic [CODE_W-1:0] CP_MIN3     = 21'h000800;
   localparam logic [CODE_W-1:0] CP_REPLACE  = 21'h00FFFD;
   localparam logic [5:0]        HI_SUR_TAG  = 6'b110110;
   localparam logic [5:0]        LO_SUR_TAG  = 6'b110111;

   typedef struct packed {
      logic error_policy;
      logic unit_mode;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_unit;
      logic              has_unit;
      logic              is_replacement;
      logic [CERT_W-1:0] certainty;
      logic              end_of_stream;
   } result_type;

   // all results caused by one byte, slot 0 goes out first
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [CNT_W-1:0]             count;
   } bundle_type;

endpackage

[hw/rtl/u2u_decode.sv]
// ----------------------------------------------------------------------------
// u2u_decode: byte decoder and stream state
// Decodes one registered byte against the open sequence, checks it, and
// builds the bundle of result beats it causes; holds the per-stream state.
// ----------------------------------------------------------------------------
module u2u_decode (
   input  logic                clock,
   input  logic                reset,
   input  u2u_pkg::cfg_type    cfg,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output u2u_pkg::bundle_type bundle
);
   import u2u_pkg::*;

   // stream state
   logic [2:0]        need_ff, need_in;
   logic [2:0]        seen_ff, seen_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic              stopped_ff, stopped_in;
   logic              nonascii_ff, nonascii_in;
   logic              error_ff, error_in;

   logic              char_ok;
   logic [CODE_W-1:0] char_cp;
   logic              err_raise;
   logic [2:0]        seen_inc;
   logic [CODE_W-1:0] acc_shift;
   logic [CODE_W-1:0] cp_min;
   logic              emit;
   logic [CODE_W-1:0] emit_cp;
   logic [19:0]       supp_off;
   logic [CODE_W-1:0] supp_diff;
   result_type        unit_hi, unit_lo, end_res;
   logic [1:0]        n_units;

   assign seen_inc  = seen_ff + 3'd1;
   assign acc_shift = {acc_ff[CODE_W-7:0], data_byte[5:0]};

   always_comb begin
      case (need_ff)
         3'd2:    cp_min = CP_MIN2;
         3'd3:    cp_min = CP_MIN3;
         default: cp_min = CP_SUPP;
      endcase
   end

   // byte processing and end-of-stream handling
   always_comb begin
      need_in     = need_ff;
      seen_in     = seen_ff;
      acc_in      = acc_ff;
      stopped_in  = stopped_ff;
      nonascii_in = nonascii_ff;
      error_in    = error_ff;
      char_ok     = 1'b0;
      char_cp     = acc_shift;
      err_raise   = 1'b0;

      if (!stopped_ff) begin
         if (need_ff == 3'd0) begin
            char_cp = {13'd0, data_byte};
            if (data_byte[7] == 1'b0) begin
               char_ok = 1'b1;
            end else if (data_byte inside {[8'hC2:8'hDF]}) begin
               need_in = 3'd2;
               seen_in = 3'd1;
               acc_in  = {16'd0, data_byte[4:0]};
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
               need_in = 3'd3;
               seen_in = 3'd1;
               acc_in  = {17'd0, data_byte[3:0]};
            end else if (data_byte inside {[8'hF0:8'hF4]}) begin
               need_in = 3'd4;
               seen_in = 3'd1;
               acc_in  = {18'd0, data_byte[2:0]};
            end else begin
               err_raise = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            // broken sequence, the offending byte goes with it
            need_in   = 3'd0;
            seen_in   = 3'd0;
            acc_in    = '0;
            err_raise = 1'b1;
         end else if (seen_inc >= need_ff) begin
            need_in = 3'd0;
            seen_in = 3'd0;
            acc_in  = '0;
            if (acc_shift < cp_min || acc_shift > CP_MAX ||
                (acc_shift >= CP_SUR_LO && acc_shift <= CP_SUR_HI)) begin
               err_raise = 1'b1;
            end else begin
               char_ok     = 1'b1;
               nonascii_in = 1'b1;
            end
         end else begin
            seen_in = seen_inc;
            acc_in  = acc_shift;
         end
      end

      if (err_raise) begin
         error_in = 1'b1;
         if (!cfg.error_policy) stopped_in = 1'b1;
      end

      // truncated sequence at the end of the stream
      if (last_byte && !stopped_in && need_in != 3'd0) begin
         err_raise = 1'b1;
         error_in  = 1'b1;
         if (!cfg.error_policy) stopped_in = 1'b1;
      end

      // end beat: class of the stream, then back to a clean stream
      end_res                = '0;
      end_res.end_of_stream  = 1'b1;
      end_res.certainty      = error_in ? CERT_INVALID :
                               (nonascii_in ? CERT_UTF8 : CERT_ASCII);
      if (last_byte) begin
         need_in     = 3'd0;
         seen_in     = 3'd0;
         acc_in      = '0;
         stopped_in  = 1'b0;
         nonascii_in = 1'b0;
         error_in    = 1'b0;
      end
   end

   // character to UTF-16 units or a whole code point
   assign emit      = char_ok || (err_raise && cfg.error_policy);
   assign emit_cp   = err_raise ? CP_REPLACE : char_cp;
   assign supp_diff = emit_cp - CP_SUPP;
   assign supp_off  = supp_diff[19:0];

   always_comb begin
      unit_hi                = '0;
      unit_lo                = '0;
      unit_hi.has_unit       = 1'b1;
      unit_lo.has_unit       = 1'b1;
      unit_hi.is_replacement = err_raise;
      unit_lo.is_replacement = err_raise;
      n_units                = 2'd0;
      if (emit) begin
         if (!cfg.unit_mode && emit_cp > CP_BMP_MAX) begin
            unit_hi.code_unit = {5'd0, HI_SUR_TAG, supp_off[19:10]};
            unit_lo.code_unit = {5'd0, LO_SUR_TAG, supp_off[9:0]};
            n_units           = 2'd2;
         end else begin
            unit_hi.code_unit = emit_cp;
            n_units           = 2'd1;
         end
      end
   end

   // pack the bundle, end beat after any units
   always_comb begin
      bundle.slot[0] = (n_units != 2'd0) ? unit_hi : end_res;
      bundle.slot[1] = (n_units == 2'd2) ? unit_lo : end_res;
      bundle.slot[2] = end_res;
      bundle.count   = n_units + {1'b0, last_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff     <= 3'd0;
         seen_ff     <= 3'd0;
         acc_ff      <= '0;
         stopped_ff  <= 1'b0;
         nonascii_ff <= 1'b0;
         error_ff    <= 1'b0;
      end else if (step) begin
         need_ff     <= need_in;
         seen_ff     <= seen_in;
         acc_ff      <= acc_in;
         stopped_ff  <= stopped_in;
         nonascii_ff <= nonascii_in;
         error_ff    <= error_in;
      end
   end

endmodule

[hw/rtl/u2u_serial.sv]
// ----------------------------------------------------------------------------
// u2u_serial: result register and beat sequencer
// Holds the bundle of one byte and hands its beats out one per cycle while
// rsp_ready is high; takes the next bundle in the cycle the last beat leaves.
// ----------------------------------------------------------------------------
module u2u_serial (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  u2u_pkg::bundle_type bundle,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output u2u_pkg::result_type rsp_beat
);
   import u2u_pkg::*;

   result_type [MAX_RESULTS-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]             left_ff, left_in;
   logic                         fire;

   assign rsp_valid = (left_ff != '0);
   assign fire      = rsp_valid && rsp_ready;
   assign free      = (left_ff == '0) || (left_ff == CNT_W'(1) && rsp_ready);
   assign rsp_beat  = slot_ff[0];

   // load a new bundle or shift the taken beat out
   always_comb begin
      slot_in = slot_ff;
      left_in = left_ff;
      if (load) begin
         slot_in = bundle.slot;
         left_in = bundle.count;
      end else if (fire) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         left_in    = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

endmodule

[hw/rtl/utf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder: streaming UTF-8 decoder with validation
// Bytes in, UTF-16 code units or code points out, with error replacement or
// stop, and a stream class on the final beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one UTF-8 byte per beat, req_last_byte on the final byte.
//   rsp_*  : result beats; a byte gives none, one unit, a surrogate pair or
//            an error unit, and the final byte adds an end beat with
//            rsp_end_of_stream and the stream class in rsp_certainty.
//   csr_*  : register writes, taken in the cycle csr_we is high; the user
//            writes only while the block is idle, not enforced by the block.
// Path: an accepted byte waits in the input register until the result
//   register is free, is then decoded, and its bundle loaded there to go out.
// Throughput: one byte a cycle while rsp_ready is high and each byte yields
//   at most one beat; a byte with more result beats (up to 3) holds the input
//   until they drain through the single result port, one beat per cycle.
// Reset: clears the control registers, the open sequence and stream flags.
// Stall: with rsp_ready low the held bundle waits, the input register fills,
//   and req_ready then drops until the bundle drains.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [u2u_pkg::CODE_W-1:0]     rsp_code_unit,
   output logic                           rsp_has_unit,
   output logic                           rsp_is_replacement,
   output logic [u2u_pkg::CERT_W-1:0]     rsp_certainty,
   output logic                           rsp_end_of_stream,
   input  logic                           csr_we,
   input  logic [u2u_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [u2u_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import u2u_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       ser_free;
   logic       step;
   logic       load;
   bundle_type bundle;
   result_type rsp_beat;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ERROR_POLICY: cfg_in.error_policy = csr_wdata[0];
            CSR_UNIT_MODE:    cfg_in.unit_mode    = csr_wdata[0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   // input register: decoded once the result register can take the bundle
   assign step        = in_valid_ff && ser_free;
   assign load        = step && (bundle.count != '0);
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   u2u_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .bundle    (bundle)
   );

   u2u_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (ser_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_code_unit      = rsp_beat.code_unit;
   assign rsp_has_unit       = rsp_beat.has_unit;
   assign rsp_is_replacement = rsp_beat.is_replacement;
   assign rsp_certainty      = rsp_beat.certainty;
   assign rsp_end_of_stream  = rsp_beat.end_of_stream;

endmodule

[sim/tb_utf8_to_utf16_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder: self-checking bench for the UTF-8 decoder
// Streams of UTF-8 bytes go in through the request channel. A behavioural
// decoder inside the bench predicts every result beat: units, surrogate
// pairs, replacement characters and the stream class. The result checker
// compares each beat field by field. Directed streams come first. Random
// streams follow, mostly well formed with some noise, truncated and
// out-of-range sequences. Both sides stall at random, except in the last part.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder;
   import u2u_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTS    = 10;

   // ports of the block
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CODE_W-1:0]     rsp_code_unit;
   logic                  rsp_has_unit;
   logic                  rsp_is_replacement;
   logic [CERT_W-1:0]     rsp_certainty;
   logic                  rsp_end_of_stream;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ERROR_POLICY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // decoder shadow state
   cfg_type           live_cfg = '0;
   logic [2:0]        open_len = '0;
   logic [2:0]        open_taken = '0;
   logic [CODE_W-1:0] cp_gather = '0;
   bit                halted = 1'b0;
   bit                saw_non_ascii = 1'b0;
   bit                saw_error = 1'b0;

   // bench bookkeeping
   result_type  units_due[$];
   logic [7:0]  stream_bytes[$];
   result_type  seen_unit;
   result_type  want_unit;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          stuck_cycles = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;

   utf8_to_utf16_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_code_unit      (rsp_code_unit),
      .rsp_has_unit       (rsp_has_unit),
      .rsp_is_replacement (rsp_is_replacement),
      .rsp_certainty      (rsp_certainty),
      .rsp_end_of_stream  (rsp_end_of_stream),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder shadow
   // ------------------------------------------------------------------------
   function automatic void queue_unit(logic [CODE_W-1:0] code, logic has, logic rep,
                                      logic [CERT_W-1:0] cert, logic eos);
      result_type r;
      r.code_unit      = code;
      r.has_unit       = has;
      r.is_replacement = rep;
      r.certainty      = cert;
      r.end_of_stream  = eos;
      units_due = {units_due, r};
   endfunction

   // one code point out, split into a surrogate pair when UTF-16 units are wanted
   function automatic void emit_char(logic [CODE_W-1:0] cp, logic rep);
      logic [CODE_W-1:0] offset;
      offset = cp - CP_SUPP;
      if (live_cfg.unit_mode || cp <= CP_BMP_MAX) begin
         queue_unit(cp, 1'b1, rep, CERT_ASCII, 1'b0);
      end else begin
         queue_unit({5'd0, HI_SUR_TAG, offset[19:10]}, 1'b1, rep, CERT_ASCII, 1'b0);
         queue_unit({5'd0, LO_SUR_TAG, offset[9:0]}, 1'b1, rep, CERT_ASCII, 1'b0);
      end
   endfunction

   function automatic void flag_error();
      saw_error = 1'b1;
      if (live_cfg.error_policy)
         emit_char(CP_REPLACE, 1'b1);
      else
         halted = 1'b1;
   endfunction

   function automatic void drop_sequence();
      open_len   = '0;
      open_taken = '0;
      cp_gather  = '0;
   endfunction

   // last byte of a sequence: reject overlong, surrogate and out-of-range values
   function automatic void close_sequence();
      logic [CODE_W-1:0] floor_cp;
      logic [CODE_W-1:0] cp;
      cp = cp_gather;
      if (open_len == 3'd2)
         floor_cp = CP_MIN2;
      else if (open_len == 3'd3)
         floor_cp = CP_MIN3;
      else
         floor_cp = CP_SUPP;
      drop_sequence();
      if (cp < floor_cp || cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)) begin
         flag_error();
      end else begin
         saw_non_ascii = 1'b1;
         emit_char(cp, 1'b0);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic is_last);
      logic [CERT_W-1:0] cert;
      if (!halted) begin
         if (open_len == 3'd0) begin
            if (b < 8'h80) begin
               emit_char({13'd0, b}, 1'b0);
            end else if (b < 8'hC2) begin
               flag_error();
            end else if (b < 8'hE0) begin
               open_len = 3'd2; cp_gather = {16'd0, b[4:0]}; open_taken = 3'd1;
            end else if (b < 8'hF0) begin
               open_len = 3'd3; cp_gather = {17'd0, b[3:0]}; open_taken = 3'd1;
            end else if (b <= 8'hF4) begin
               open_len = 3'd4; cp_gather = {18'd0, b[2:0]}; open_taken = 3'd1;
            end else begin
               flag_error();
            end
         end else if (b[7:6] != 2'b10) begin
            // broken sequence, the offending byte goes with it
            drop_sequence();
            flag_error();
         end else begin
            cp_gather  = {cp_gather[14:0], b[5:0]};
            open_taken = open_taken + 3'd1;
            if (open_taken >= open_len)
               close_sequence();
         end
      end
      if (is_last) begin
         // truncated sequence at the end of the stream
         if (!halted && open_len != 3'd0) begin
            drop_sequence();
            flag_error();
         end
         cert = saw_error ? CERT_INVALID : (saw_non_ascii ? CERT_UTF8 : CERT_ASCII);
         queue_unit('0, 1'b0, 1'b0, cert, 1'b1);
         drop_sequence();
         halted        = 1'b0;
         saw_non_ascii = 1'b0;
         saw_error     = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   function automatic bit unit_matches(result_type a, result_type b);
      return a.code_unit === b.code_unit && a.has_unit === b.has_unit &&
             a.is_replacement === b.is_replacement && a.certainty === b.certainty &&
             a.end_of_stream === b.end_of_stream;
   endfunction

   task automatic report_mismatch(string what, result_type want, result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, what);
         $display("   want unit=%06h has=%b rep=%b cert=%0d eos=%b", want.code_unit,
                  want.has_unit, want.is_replacement, want.certainty, want.end_of_stream);
         $display("   got  unit=%06h has=%b rep=%b cert=%0d eos=%b", got.code_unit,
                  got.has_unit, got.is_replacement, got.certainty, got.end_of_stream);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_unit.code_unit      = rsp_code_unit;
         seen_unit.has_unit       = rsp_has_unit;
         seen_unit.is_replacement = rsp_is_replacement;
         seen_unit.certainty      = rsp_certainty;
         seen_unit.end_of_stream  = rsp_end_of_stream;
         if (units_due.size() == 0) begin
            report_mismatch("result beat with nothing expected", '0, seen_unit);
         end else begin
            want_unit = units_due.pop_front();
            if (!unit_matches(want_unit, seen_unit))
               report_mismatch("result beat mismatch", want_unit, seen_unit);
         end
      end
   end

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      stream_bytes.delete();
   endtask

   // block idle: nothing outstanding, then time for a byte with no result
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (units_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic policy, input logic mode);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_ERROR_POLICY;
      csr_wdata <= policy;
      @(posedge clock);
      live_cfg.error_policy = policy;
      csr_index <= CSR_UNIT_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      live_cfg.unit_mode = mode;
      csr_we <= 1'b0;
   endtask

   // append one byte to the stream being built
   function automatic void add_byte(logic [7:0] b);
      stream_bytes = {stream_bytes, b};
   endfunction

   function automatic void encode_cp(logic [CODE_W-1:0] cp);
      if (cp < CP_MIN2) begin
         add_byte(cp[7:0]);
      end else if (cp < CP_MIN3) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else if (cp < CP_SUPP) begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({5'b11110, cp[20:18]});
         add_byte({2'b10, cp[17:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endfunction

   function automatic logic [CODE_W-1:0] random_multibyte_cp();
      case ($urandom_range(0, 2))
         0:       return CODE_W'($urandom_range(21'h80, 21'h7FF));
         1:       return CODE_W'($urandom_range(21'h800, 21'hFFFF));
         default: return CODE_W'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
   endfunction

   function automatic logic [7:0] random_tail();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   // one character, mostly well formed, sometimes noise or a bad sequence
   function automatic void add_random_char(bit ascii_only);
      int pick;
      int start;
      pick = ascii_only ? 0 : $urandom_range(0, 19);
      if (pick <= 6) begin
         encode_cp(CODE_W'($urandom_range(0, 127)));
      end else if (pick <= 15) begin
         encode_cp(random_multibyte_cp());
      end else if (pick <= 17) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (pick == 18) begin
         // cut a multi-byte character short
         start = stream_bytes.size();
         encode_cp(random_multibyte_cp());
         repeat ($urandom_range(1, stream_bytes.size() - start - 1))
            void'(stream_bytes.pop_back());
      end else begin
         case ($urandom_range(0, 3))
            0: begin // overlong three-byte form
               add_byte(8'hE0);
               add_byte(8'($urandom_range(8'h80, 8'h9F)));
               add_byte(random_tail());
            end
            1: begin // overlong four-byte form
               add_byte(8'hF0);
               add_byte(8'($urandom_range(8'h80, 8'h8F)));
               add_byte(random_tail());
               add_byte(random_tail());
            end
            2: begin // surrogate
               add_byte(8'hED);
               add_byte(8'($urandom_range(8'hA0, 8'hBF)));
               add_byte(random_tail());
            end
            default: begin // above the last code point
               add_byte(8'hF4);
               add_byte(8'($urandom_range(8'h90, 8'hBF)));
               add_byte(random_tail());
               add_byte(random_tail());
            end
         endcase
      end
   endfunction

   task automatic run_random_streams(input int byte_target);
      bit ascii_only;
      while (bytes_sent < byte_target) begin
         if ($urandom_range(0, 2) == 0)
            set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         ascii_only = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(1, 10)) add_random_char(ascii_only);
         send_stream();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // ascii extremes, smallest two-byte and largest four-byte characters
   task automatic test_valid_chars();
      set_config(1'b1, 1'b0);
      stream_bytes = '{8'h00, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
      send_stream();
   endtask

   // continuation byte, two-byte overlong lead and top byte as leads
   task automatic test_bad_leads();
      set_config(1'b1, 1'b1);
      stream_bytes = '{8'h80, 8'hC0, 8'hFF};
      send_stream();
   endtask

   // surrogate, three-byte overlong, value above the last code point
   task automatic test_bad_values();
      set_config(1'b1, 1'b1);
      stream_bytes = '{8'hED, 8'hA0, 8'h80, 8'hE0, 8'h9F, 8'hBF,
                       8'hF4, 8'h90, 8'h80, 8'h80};
      send_stream();
   endtask

   // ascii byte breaking a sequence, then a sequence cut by the end
   task automatic test_broken_and_truncated();
      set_config(1'b1, 1'b0);
      stream_bytes = '{8'hC2, 8'h41, 8'hE2, 8'h82};
      send_stream();
   endtask

   // stop policy: nothing after the first error but the end beat
   task automatic test_stop_policy();
      set_config(1'b0, 1'b0);
      stream_bytes = '{8'hC1, 8'h41};
      send_stream();
   endtask

   task automatic test_random_streams();
      idle_on = 1'b1;
      run_random_streams(280);
   endtask

   task automatic test_unthrottled_streams();
      idle_on = 1'b0;
      run_random_streams(330);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_valid_chars();
      test_bad_leads();
      test_bad_values();
      test_broken_and_truncated();
      test_stop_policy();
      test_random_streams();
      test_unthrottled_streams();
      req_valid <= 1'b0;
      while (units_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && units_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/u2u_pkg.sv
hw/rtl/u2u_decode.sv
hw/rtl/u2u_serial.sv
hw/rtl/utf8_to_utf16_decoder.sv
sim/tb_utf8_to_utf16_decoder.sv
